[design/ultrasonic_echo_ranger_avg_defines.svh]
// Assertion macros shared by the ranger RTL
`ifndef ULTRASONIC_ECHO_RANGER_AVG_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_AVG_DEFINES_SVH

`ifndef ASSERT_OFF
`define UER_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define UER_ASSERT(lbl, clk, rst_n, prop)
`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/uer_pkg.sv]
package uer_pkg;

  localparam int SAMPLES = 5;

  localparam int CNT_W    = 20;
  localparam int SETTLE_W = 20;
  localparam int TRIG_W   = 10;
  localparam int TMO_W    = 16;
  localparam int EW_W     = 16;
  localparam int DIST_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [EW_W-1:0]  EW_MAX  = {EW_W{1'b1}};

  // distance = sum*50 / (29*SAMPLES), tracked as a running quotient and remainder
  localparam int DIV_D = 29 * SAMPLES;
  localparam int INC_Q = 50 / DIV_D;
  localparam int INC_R = 50 % DIV_D;
  localparam int Q_W   = 21;
  localparam int REM_W = $clog2(DIV_D);
  localparam int IDX_W = $clog2(SAMPLES + 1);

  localparam logic [SETTLE_W-1:0] SETTLE_RST = SETTLE_W'(200000);
  localparam logic [TRIG_W-1:0]   TRIG_RST   = TRIG_W'(10);
  localparam logic [TMO_W-1:0]    TMO_RST    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE  = 2'd0,
    REG_TRIGGER = 2'd1,
    REG_TIMEOUT = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SETTLE = 5'b00010,
    PH_TRIG   = 5'b00100,
    PH_RISE   = 5'b01000,
    PH_HIGH   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_ticks;
    logic [TRIG_W-1:0]   trigger_ticks;
    logic [TMO_W-1:0]    echo_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic action;
    logic echo_level;
  } item_t;

  typedef struct packed {
    logic [Q_W-1:0]   q;
    logic [REM_W-1:0] r;
  } acc_t;

  function automatic acc_t acc_add(input acc_t a);
    logic [REM_W:0] rs;
    acc_t res;
    rs = {1'b0, a.r} + (REM_W+1)'(INC_R);
    if (rs >= (REM_W+1)'(DIV_D)) begin
      res.r = REM_W'(rs - (REM_W+1)'(DIV_D));
      res.q = a.q + Q_W'(INC_Q + 1);
    end else begin
      res.r = rs[REM_W-1:0];
      res.q = a.q + Q_W'(INC_Q);
    end
    return res;
  endfunction

endpackage

[design/uer_in_if.sv]
interface uer_in_if;
  logic valid;
  logic ready;
  logic action;
  logic echo_level;

  modport source (output valid, output action, output echo_level, input ready);
  modport sink   (input valid, input action, input echo_level, output ready);
endinterface

[design/uer_out_if.sv]
interface uer_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_level;
  logic        busy_res;
  logic        done_res;
  logic [16:0] distance_centi_cm;
  logic        timed_out;

  modport source (output valid, output trigger_level, output busy_res, output done_res,
                  output distance_centi_cm, output timed_out, input ready);
  modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                  input distance_centi_cm, input timed_out, output ready);
endinterface

[design/uer_cfg_if.sv]
interface uer_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/uer_cfg_regs.sv]
module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  uer_cfg_if.sink   cfg_ch,
  output cfg_t      cfg
);

  logic [SETTLE_W-1:0] settle_r;
  logic [TRIG_W-1:0]   trig_r;
  logic [TMO_W-1:0]    tmo_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RST;
      trig_r   <= TRIG_RST;
      tmo_r    <= TMO_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_SETTLE:  settle_r <= cfg_ch.data[SETTLE_W-1:0];
        REG_TRIGGER: trig_r   <= cfg_ch.data[TRIG_W-1:0];
        REG_TIMEOUT: tmo_r    <= cfg_ch.data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.settle_ticks       = settle_r;
  assign cfg.trigger_ticks      = trig_r;
  assign cfg.echo_timeout_ticks = tmo_r;

endmodule

[design/uer_in_stage.sv]
module uer_in_stage
  import uer_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  uer_in_if.sink   in_ch,
  input  logic     adv,
  output logic     item_valid,
  output item_t    item
);

  logic  valid_r;
  item_t item_r;

  assign in_ch.ready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.action     <= in_ch.action;
      item_r.echo_level <= in_ch.echo_level;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[design/uer_core.sv]
module uer_core
  import uer_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      item_valid,
  input  item_t     item,
  output logic      adv,
  uer_out_if.source out_ch
);

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [EW_W-1:0]   ew_r, ew_nxt;
  acc_t              acc_r, acc_nxt, acc_inc;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              trig, done, tmo, tmo_en;
  logic              fire;

  logic              out_valid_r;
  logic              trig_r, busy_r, done_r, tmo_r;
  logic [DIST_W-1:0] dist_out_r;

  assign adv  = !out_valid_r || out_ch.ready;
  assign fire = item_valid && adv;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    ew_nxt    = ew_r;
    acc_nxt   = acc_r;
    dist_nxt  = dist_r;
    trig      = 1'b0;
    done      = 1'b0;
    tmo       = 1'b0;
    cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    acc_inc   = acc_add(acc_r);
    tmo_en    = (cfg.echo_timeout_ticks != '0);
    if (item.action) begin
      phase_nxt = PH_SETTLE;
      cnt_nxt   = '0;
      idx_nxt   = '0;
      ew_nxt    = '0;
      acc_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_SETTLE: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CNT_W'(cfg.settle_ticks)) begin
            phase_nxt = PH_TRIG;
            cnt_nxt   = '0;
          end
        end
        PH_TRIG: begin
          trig    = 1'b1;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CNT_W'(cfg.trigger_ticks)) begin
            phase_nxt = PH_RISE;
            cnt_nxt   = '0;
          end
        end
        PH_RISE: begin
          if (item.echo_level) begin
            phase_nxt = PH_HIGH;
            ew_nxt    = EW_W'(1);
            cnt_nxt   = CNT_W'(1);
            acc_nxt   = acc_inc;
          end else begin
            cnt_nxt = cnt_inc;
            if (tmo_en && cnt_inc >= CNT_W'(cfg.echo_timeout_ticks)) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              tmo       = 1'b1;
            end
          end
        end
        PH_HIGH: begin
          if (item.echo_level) begin
            if (ew_r != EW_MAX) begin
              ew_nxt  = ew_r + 1'b1;
              acc_nxt = acc_inc;
            end
            cnt_nxt = cnt_inc;
            if (tmo_en && cnt_inc >= CNT_W'(cfg.echo_timeout_ticks)) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              tmo       = 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
            cnt_nxt = '0;
            if (idx_r == IDX_W'(SAMPLES - 1)) begin
              dist_nxt  = acc_r.q[DIST_W-1:0];
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_SETTLE;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      ew_r        <= '0;
      acc_r       <= '0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        idx_r   <= idx_nxt;
        ew_r    <= ew_nxt;
        acc_r   <= acc_nxt;
        dist_r  <= dist_nxt;
      end
      if (adv) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      trig_r     <= trig;
      busy_r     <= (phase_nxt != PH_IDLE);
      done_r     <= done;
      tmo_r      <= tmo;
      dist_out_r <= dist_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.trigger_level     = trig_r;
  assign out_ch.busy_res          = busy_r;
  assign out_ch.done_res          = done_r;
  assign out_ch.timed_out         = tmo_r;
  assign out_ch.distance_centi_cm = dist_out_r;

endmodule

[design/ultrasonic_echo_ranger_avg.sv]
// Ultrasonic echo ranger, averaged over SAMPLES pings.
// in_ch  : one beat per microsecond tick (action 0, echo_level sampled) or a
//          start command (action 1).
// out_ch : exactly one result beat per input beat, in order: trigger level,
//          busy, done, timeout flag and the last completed distance in
//          hundredths of a centimetre.
// cfg_ch : register writes (0 settle, 1 trigger, 2 echo timeout), always
//          ready; write only while the block is idle.
// Path: each input beat is registered in the input stage, then passes the phase
// sequencer and result register. Throughput: one beat per cycle while out_ch is
// ready; the distance quotient is kept as a running quotient/remainder, so no
// divider sits in the path.
// Reset: synchronous, active low; phase goes idle, counters and the stored
// distance clear, registers take their default values.
// Stall: when out_ch is not ready the result is held and in_ch.ready drops
// once the input register is also full; no beat is lost or repeated.
`include "ultrasonic_echo_ranger_avg_defines.svh"

module ultrasonic_echo_ranger_avg
  import uer_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  uer_in_if.sink    in_ch,
  uer_out_if.source out_ch,
  uer_cfg_if.sink   cfg_ch
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  adv;

  uer_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  uer_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  uer_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .adv        (adv),
    .out_ch     (out_ch)
  );

  `UER_ASSERT_IMP(a_ready_only_on_stall, clk, rst_n, !in_ch.ready, out_ch.valid && !out_ch.ready && item_valid)
  `UER_ASSERT_IMP(a_tmo_is_done, clk, rst_n, out_ch.valid && out_ch.timed_out, out_ch.done_res && !out_ch.busy_res)
  `UER_ASSERT_IMP(a_done_idle, clk, rst_n, out_ch.valid && out_ch.done_res, !out_ch.busy_res && !out_ch.trigger_level)
  `UER_ASSERT_IMP(a_trig_busy, clk, rst_n, out_ch.valid && out_ch.trigger_level, out_ch.busy_res)

endmodule
